FILE: rtl/bilinear_block_predictor_macros.svh
// assertion macros shared by the checker files of the bilinear block predictor
// depends on clk and rst being visible where a macro is used
`ifndef BILINEAR_BLOCK_PREDICTOR_MACROS_SVH
`define BILINEAR_BLOCK_PREDICTOR_MACROS_SVH

// clocked check, off while reset is high
`define BBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bilinear block predictor check failed");

// clocked check that also holds through reset
`define BBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bilinear block predictor check failed");

`endif

FILE: rtl/bbp_pkg.sv
// shared types and constants of the bilinear block predictor
// no dependencies; used by the top level and its checker
package bbp_pkg;

  // span and offset width
  localparam int SPAN_BITS = 10;
  // weight and span product width
  localparam int W_W = 2 * SPAN_BITS;
  // weighted sum width (grey value times span product)
  localparam int N_W = W_W + 8;
  // threshold product width (q8.8 epsilon times span product)
  localparam int T_W = W_W + 16;
  // quotient bits, one divider stage each
  localparam int Q_BITS = 8;
  // normalize, weights, products, sum
  localparam int FRONT_STAGES = 4;
  // front stages, difference stage, divider stages (last one is the output)
  localparam int N_STAGES = FRONT_STAGES + 1 + Q_BITS;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_EPSILON = '0;
  localparam logic [15:0] EPS_RESET = 16'd2560;

  typedef struct packed {
    logic [7:0]           corner_top_left;
    logic [7:0]           corner_top_right;
    logic [7:0]           corner_bottom_left;
    logic [7:0]           corner_bottom_right;
    logic [SPAN_BITS-1:0] row_span;
    logic [SPAN_BITS-1:0] col_span;
    logic [SPAN_BITS-1:0] row_offset;
    logic [SPAN_BITS-1:0] col_offset;
    logic [7:0]           pixel_value;
  } pix_t;

  typedef struct packed {
    logic [7:0] estimate;
    logic       exceeds;
  } est_t;

endpackage

FILE: rtl/bilinear_block_predictor.sv
// bilinear block predictor: corner interpolation and homogeneity flag per pixel
// depends on bbp_pkg
//
// usage
//   pix channel (pix_valid/pix_ready/pix): one pixel word per accepted cycle,
//     carrying the four block corners, the spans, the pixel offsets and value
//   est channel (est_valid/est_ready/est): one result word per pixel, in order,
//     the truncated bilinear estimate and the flag that the pixel is farther
//     from the exact estimate than epsilon
//   apb port: register 0 at byte address 0 is epsilon_q8 (q8.8, reset 10.0);
//     write it only while no pixel is in flight
//   throughput: one pixel per cycle, sustained
//   latency: 13 cycles from pixel accept to result valid, set by the pipeline:
//     span normalize, five span multipliers, corner and threshold multipliers,
//     weighted sum, difference, then eight divider stages of one quotient bit
//   reset: synchronous; empties the pipeline and restores epsilon
//   stall: while est_ready is low the result holds; the stages behind it keep
//     moving until each holds a word, so bubbles close up and pix_ready falls
//     only once every stage is full
module bilinear_block_predictor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  bbp_pkg::pix_t                pix,
  output logic                         est_valid,
  input  logic                         est_ready,
  output bbp_pkg::est_t                est,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [bbp_pkg::DATA_W-1:0]   pwdata,
  output logic [bbp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bbp_pkg::*;

  localparam int S = SPAN_BITS;

  // stage 1: normalized spans and offsets
  typedef struct packed {
    logic [7:0]   tl;
    logic [7:0]   tr;
    logic [7:0]   bl;
    logic [7:0]   br;
    logic [7:0]   px;
    logic [S-1:0] rs;
    logic [S-1:0] cs;
    logic [S-1:0] ro;
    logic [S-1:0] co;
  } norm_t;

  // stage 2: corner weights and span product
  typedef struct packed {
    logic [7:0]     tl;
    logic [7:0]     tr;
    logic [7:0]     bl;
    logic [7:0]     br;
    logic [7:0]     px;
    logic [W_W-1:0] w_tl;
    logic [W_W-1:0] w_tr;
    logic [W_W-1:0] w_bl;
    logic [W_W-1:0] w_br;
    logic [W_W-1:0] den;
  } wgt_t;

  // stage 3: weighted corners, pixel times span product, threshold
  typedef struct packed {
    logic [N_W-1:0] p_tl;
    logic [N_W-1:0] p_tr;
    logic [N_W-1:0] p_bl;
    logic [N_W-1:0] p_br;
    logic [N_W-1:0] lhs;
    logic [T_W-1:0] thr;
    logic [W_W-1:0] den;
  } prod_t;

  // stage 4: weighted sum
  typedef struct packed {
    logic [N_W-1:0] num;
    logic [N_W-1:0] lhs;
    logic [T_W-1:0] thr;
    logic [W_W-1:0] den;
  } sum_t;

  // stage 5: absolute difference, divider input
  typedef struct packed {
    logic [N_W-1:0] num;
    logic [N_W-1:0] diff;
    logic [T_W-1:0] thr;
    logic [W_W-1:0] den;
  } dif_t;

  // divider stages
  typedef struct packed {
    logic [N_W-1:0] rem;
    logic [W_W-1:0] den;
    logic [7:0]     q;
    logic           flag;
  } div_t;

  // one restoring step, quotient bits enter from the right msb first
  function automatic div_t div_step(div_t cur, int unsigned k);
    logic [N_W-1:0] sub;
    div_t           nxt;
    sub = N_W'(cur.den) << k;
    nxt = cur;
    if (cur.rem >= sub) begin
      nxt.rem = cur.rem - sub;
      nxt.q   = {cur.q[6:0], 1'b1};
    end else begin
      nxt.q   = {cur.q[6:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [N_STAGES-1:0] v;
  logic [N_STAGES-1:0] load;

  norm_t s1;
  wgt_t  s2;
  prod_t s3;
  sum_t  s4;
  dif_t  d0;
  div_t  dv [1:Q_BITS];

  logic [15:0] epsilon;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      // writes beyond the register list are dropped
      if (paddr[ADDR_W-1:2] == REG_EPSILON) begin
        epsilon <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_EPSILON) begin
      prdata = {{(DATA_W-16){1'b0}}, epsilon};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: a stage loads when empty or when its word moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    load[N_STAGES-1] = !v[N_STAGES-1] || est_ready;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      load[i] = !v[i] || load[i+1];
    end
  end

  assign pix_ready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= pix_valid;
      end
      for (int i = 1; i < N_STAGES; i++) begin
        if (load[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: zero span means offset 0 over span 1, offsets clamp to the span
  // ---------------------------------------------------------------------------
  logic [S-1:0] rs_n, cs_n, ro_n, co_n;

  always_comb begin
    rs_n = pix.row_span;
    ro_n = pix.row_offset;
    cs_n = pix.col_span;
    co_n = pix.col_offset;
    if (rs_n == '0) begin
      rs_n = S'(1);
      ro_n = '0;
    end
    if (cs_n == '0) begin
      cs_n = S'(1);
      co_n = '0;
    end
    if (ro_n > rs_n) begin
      ro_n = rs_n;
    end
    if (co_n > cs_n) begin
      co_n = cs_n;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 inputs: distances to the far edges
  // ---------------------------------------------------------------------------
  logic [S-1:0] row_rest, col_rest;

  assign row_rest = s1.rs - s1.ro;
  assign col_rest = s1.cs - s1.co;

  // stage 4 input: the four weighted corners summed, fits since each weight
  // sum equals the span product
  logic [N_W-1:0] num_sum;

  assign num_sum = s3.p_tl + s3.p_tr + s3.p_bl + s3.p_br;

  // stage 5 input
  logic [N_W-1:0] abs_diff;

  assign abs_diff = (s4.lhs >= s4.num) ? (s4.lhs - s4.num) : (s4.num - s4.lhs);

  // first divider step also settles the flag: |px*den - num| * 256 > eps * den
  div_t div_first;

  always_comb begin
    div_first.rem  = d0.num;
    div_first.den  = d0.den;
    div_first.q    = '0;
    div_first.flag = ({d0.diff, 8'b0} > d0.thr);
  end

  // ---------------------------------------------------------------------------
  // pipeline data registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1.tl <= pix.corner_top_left;
      s1.tr <= pix.corner_top_right;
      s1.bl <= pix.corner_bottom_left;
      s1.br <= pix.corner_bottom_right;
      s1.px <= pix.pixel_value;
      s1.rs <= rs_n;
      s1.cs <= cs_n;
      s1.ro <= ro_n;
      s1.co <= co_n;
    end

    if (load[1]) begin
      s2.tl   <= s1.tl;
      s2.tr   <= s1.tr;
      s2.bl   <= s1.bl;
      s2.br   <= s1.br;
      s2.px   <= s1.px;
      s2.w_tl <= W_W'(row_rest) * W_W'(col_rest);
      s2.w_tr <= W_W'(row_rest) * W_W'(s1.co);
      s2.w_bl <= W_W'(s1.ro) * W_W'(col_rest);
      s2.w_br <= W_W'(s1.ro) * W_W'(s1.co);
      s2.den  <= W_W'(s1.rs) * W_W'(s1.cs);
    end

    if (load[2]) begin
      s3.p_tl <= N_W'(s2.tl) * N_W'(s2.w_tl);
      s3.p_tr <= N_W'(s2.tr) * N_W'(s2.w_tr);
      s3.p_bl <= N_W'(s2.bl) * N_W'(s2.w_bl);
      s3.p_br <= N_W'(s2.br) * N_W'(s2.w_br);
      s3.lhs  <= N_W'(s2.px) * N_W'(s2.den);
      s3.thr  <= T_W'(epsilon) * T_W'(s2.den);
      s3.den  <= s2.den;
    end

    if (load[3]) begin
      s4.num <= num_sum;
      s4.lhs <= s3.lhs;
      s4.thr <= s3.thr;
      s4.den <= s3.den;
    end

    if (load[FRONT_STAGES]) begin
      d0.num  <= s4.num;
      d0.diff <= abs_diff;
      d0.thr  <= s4.thr;
      d0.den  <= s4.den;
    end

    if (load[FRONT_STAGES+1]) begin
      dv[1] <= div_step(div_first, Q_BITS - 1);
    end

    for (int j = 1; j < Q_BITS; j++) begin
      if (load[FRONT_STAGES+j+1]) begin
        dv[j+1] <= div_step(dv[j], Q_BITS - 1 - j);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output: last divider stage is the result register
  // ---------------------------------------------------------------------------
  assign est_valid    = v[N_STAGES-1];
  assign est.estimate = dv[Q_BITS].q;
  assign est.exceeds  = dv[Q_BITS].flag;

endmodule

FILE: rtl/bbp_checker.sv
// port-level checks for the bilinear block predictor, bound to the top level
// depends on bbp_pkg and bilinear_block_predictor_macros.svh
`include "bilinear_block_predictor_macros.svh"

module bbp_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_valid,
  input logic          pix_ready,
  input logic          est_valid,
  input logic          est_ready,
  input bbp_pkg::est_t est,
  input logic          pready
);
  import bbp_pkg::*;

  localparam int CNT_W = $clog2(N_STAGES + 1);

  // words accepted but not yet delivered
  logic [CNT_W-1:0] outstanding;
  logic             pix_take;
  logic             est_take;

  assign pix_take = pix_valid && pix_ready;
  assign est_take = est_valid && est_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (pix_take && !est_take) begin
      outstanding <= outstanding + CNT_W'(1);
    end else if (est_take && !pix_take) begin
      outstanding <= outstanding - CNT_W'(1);
    end
  end

  // a stalled result holds its word
  `BBP_ASSERT(a_est_hold, est_valid && !est_ready |=> est_valid && $stable(est))
  // no result without a pixel in flight
  `BBP_ASSERT(a_no_phantom, est_valid |-> outstanding != '0)
  // a full pipeline behind a stalled output takes no pixel
  `BBP_ASSERT(a_full_stall, (outstanding == CNT_W'(N_STAGES)) && !est_ready |-> !pix_ready)
  // the register port never waits
  `BBP_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind bilinear_block_predictor bbp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .est_valid (est_valid),
  .est_ready (est_ready),
  .est       (est),
  .pready    (pready)
);
